>>> hdl/ptl_pkg.sv
// ----------------------------------------------------------------------------
// Pedestrian traffic light package
// Shared types, phase codes, register indexes and reset values for the
// pedestrian traffic light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

    // Phase codes.
    localparam logic [2:0] PH_GREEN     = 3'd0;
    localparam logic [2:0] PH_CAR_BLINK = 3'd1;
    localparam logic [2:0] PH_RED       = 3'd2;
    localparam logic [2:0] PH_BLINK_IN  = 3'd3;
    localparam logic [2:0] PH_WALK      = 3'd4;
    localparam logic [2:0] PH_BLINK_OUT = 3'd5;

    // Blink part codes: on, off, on.
    localparam logic [1:0] BP_ON_FIRST  = 2'd0;
    localparam logic [1:0] BP_OFF       = 2'd1;
    localparam logic [1:0] BP_ON_LAST   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SLICE_TICKS      = 3'd0;
    localparam logic [2:0] REG_SLICES_PER_PHASE = 3'd1;
    localparam logic [2:0] REG_CAR_ON_TICKS     = 3'd2;
    localparam logic [2:0] REG_CAR_OFF_TICKS    = 3'd3;
    localparam logic [2:0] REG_BOTH_ON_TICKS    = 3'd4;
    localparam logic [2:0] REG_BOTH_OFF_TICKS   = 3'd5;
    localparam logic [2:0] REG_WALK_TICKS       = 3'd6;
    localparam logic [2:0] REG_BLINK_ROUNDS     = 3'd7;

    // Register reset values.
    localparam logic [11:0] RST_SLICE_TICKS      = 12'd68;
    localparam logic [7:0]  RST_SLICES_PER_PHASE = 8'd50;
    localparam logic [11:0] RST_CAR_ON_TICKS     = 12'd380;
    localparam logic [11:0] RST_CAR_OFF_TICKS    = 12'd180;
    localparam logic [11:0] RST_BOTH_ON_TICKS    = 12'd390;
    localparam logic [11:0] RST_BOTH_OFF_TICKS   = 12'd190;
    localparam logic [15:0] RST_WALK_TICKS       = 16'd5000;
    localparam logic [7:0]  RST_BLINK_ROUNDS     = 8'd5;

    typedef struct packed {
        logic [11:0] slice_ticks;
        logic [7:0]  slices_per_phase;
        logic [11:0] car_on_ticks;
        logic [11:0] car_off_ticks;
        logic [11:0] both_on_ticks;
        logic [11:0] both_off_ticks;
        logic [15:0] walk_ticks;
        logic [7:0]  blink_rounds;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  phase;
        logic        came_from_red;
        logic        request_pending;
        logic [15:0] tick_count;
        logic [7:0]  round_count;
        logic [1:0]  blink_part;
    } t_state;

    typedef struct packed {
        logic [2:0] phase_now;
        logic       walk_red;
        logic       walk_yellow;
        logic       walk_green;
        logic       car_red;
        logic       car_yellow;
        logic       car_green;
    } t_lamps;

    // Move to a new phase with all its counters cleared.
    function automatic t_state enter_phase(input t_state s, input logic [2:0] p);
        t_state r;
        r             = s;
        r.phase       = p;
        r.tick_count  = '0;
        r.round_count = '0;
        r.blink_part  = BP_ON_FIRST;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/pedestrian_traffic_light_fsm.sv
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller
// Car and pedestrian lamp sequencer with a latched pedestrian button.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave stream is one 1 ms tick; s_axis_tdata[0] is set
// when a button press edge occurred during that tick. For every tick the
// master stream returns one request holding the six lamp states and the
// phase code of that tick.
// A tick accepted at one edge has its lamp states on m_axis_tdata from the
// next cycle on. Throughput is one tick per cycle while the receiver keeps
// taking results; the state update is a single pass of logic between the
// state register and the output register.
// The output register holds a result until the receiver takes it. While the
// receiver stalls, s_axis_tready stays high only if the output register is
// empty; otherwise the sender waits, and nothing is lost or repeated.
// Timing registers are written through the cfg channel, which is always
// ready; writes are meant for idle periods between ticks.
// A synchronous low reset restores the timing defaults, enters the car
// green phase with no pending request, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pedestrian_traffic_light_fsm
    import ptl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] button_press, [7:1] zero
    // Lamp stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] car_green, [1] car_yellow,
                                        // [2] car_red, [3] walk_green,
                                        // [4] walk_yellow, [5] walk_red,
                                        // [8:6] phase_now, [15:9] zero
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_lamps step_lamps;
    t_lamps r_out;
    logic   r_out_valid;
    logic   in_acc;
    logic   out_acc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = r_out_valid && m_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slice_ticks      <= RST_SLICE_TICKS;
            r_cfg.slices_per_phase <= RST_SLICES_PER_PHASE;
            r_cfg.car_on_ticks     <= RST_CAR_ON_TICKS;
            r_cfg.car_off_ticks    <= RST_CAR_OFF_TICKS;
            r_cfg.both_on_ticks    <= RST_BOTH_ON_TICKS;
            r_cfg.both_off_ticks   <= RST_BOTH_OFF_TICKS;
            r_cfg.walk_ticks       <= RST_WALK_TICKS;
            r_cfg.blink_rounds     <= RST_BLINK_ROUNDS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SLICE_TICKS:      r_cfg.slice_ticks      <= i_cfg_data[11:0];
                REG_SLICES_PER_PHASE: r_cfg.slices_per_phase <= i_cfg_data[7:0];
                REG_CAR_ON_TICKS:     r_cfg.car_on_ticks     <= i_cfg_data[11:0];
                REG_CAR_OFF_TICKS:    r_cfg.car_off_ticks    <= i_cfg_data[11:0];
                REG_BOTH_ON_TICKS:    r_cfg.both_on_ticks    <= i_cfg_data[11:0];
                REG_BOTH_OFF_TICKS:   r_cfg.both_off_ticks   <= i_cfg_data[11:0];
                REG_WALK_TICKS:       r_cfg.walk_ticks       <= i_cfg_data;
                REG_BLINK_ROUNDS:     r_cfg.blink_rounds     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The step logic works on the state left by the previous tick.
    ptl_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_press (s_axis_tdata[0]),
        .o_next  (n_state),
        .o_lamps (step_lamps)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= step_lamps;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.phase_now, r_out.walk_red, r_out.walk_yellow,
                            r_out.walk_green, r_out.car_red, r_out.car_yellow,
                            r_out.car_green};

`ifndef ASSERT_OFF
    // The walk phase is only reached with a latched request.
    a_walk_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_WALK) |-> r_state.request_pending)
        else $error("walk phase without a pending request");

    // An accepted tick always leaves a result in the output register.
    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted tick produced no result");

    // The blink sequence only uses on, off and on parts.
    a_blink_part_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.blink_part != 2'd3)
        else $error("blink part out of range");

    // A lit car green lamp belongs to the green phase, with the walk lamp red.
    a_green_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.car_green) |->
            (r_out.phase_now == PH_GREEN) && r_out.walk_red && !r_out.walk_green)
        else $error("car green lamp outside green phase");
`endif

endmodule

`default_nettype wire

>>> hdl/ptl_step.sv
// ----------------------------------------------------------------------------
// Pedestrian traffic light step logic
// Computes the lamp states of one tick and the controller state that
// follows it, from the current state, the press flag and the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_step
    import ptl_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_state i_state,
    input  logic   i_press,
    output t_state o_next,
    output t_lamps o_lamps
);

    t_state      s_eff;
    logic [15:0] tc_inc;
    logic [7:0]  rc_inc;
    logic [11:0] on_t;
    logic [11:0] off_t;
    logic [11:0] dur;
    logic        tick_lt_dur;
    logic        blink_end;
    logic        rounds_hit;
    logic        slices_hit;
    logic        on_part;

    // Unused phase codes restart the green phase.
    always_comb begin
        if (i_state.phase > PH_BLINK_OUT) begin
            s_eff = enter_phase(i_state, PH_GREEN);
        end else begin
            s_eff = i_state;
        end
    end

    assign tc_inc  = s_eff.tick_count + 16'd1;
    assign rc_inc  = s_eff.round_count + 8'd1;
    assign on_t    = (s_eff.phase == PH_CAR_BLINK) ? i_cfg.car_on_ticks : i_cfg.both_on_ticks;
    assign off_t   = (s_eff.phase == PH_CAR_BLINK) ? i_cfg.car_off_ticks : i_cfg.both_off_ticks;
    assign dur     = (s_eff.blink_part == BP_OFF) ? off_t : on_t;
    assign on_part = (s_eff.blink_part != BP_OFF);

    assign tick_lt_dur = (tc_inc < {4'd0, dur});
    assign blink_end   = !tick_lt_dur && (s_eff.blink_part >= BP_ON_LAST);
    assign rounds_hit  = (rc_inc >= i_cfg.blink_rounds) || (i_cfg.blink_rounds == 8'd0);
    assign slices_hit  = (rc_inc >= i_cfg.slices_per_phase) || (i_cfg.slices_per_phase == 8'd0);

    // Lamp states for this tick.
    always_comb begin
        o_lamps           = '0;
        o_lamps.phase_now = s_eff.phase;
        unique case (s_eff.phase)
            PH_GREEN: begin
                o_lamps.car_green = 1'b1;
                o_lamps.walk_red  = 1'b1;
            end
            PH_CAR_BLINK: begin
                o_lamps.car_yellow = on_part;
                o_lamps.walk_red   = 1'b1;
            end
            PH_RED: begin
                o_lamps.car_red  = 1'b1;
                o_lamps.walk_red = 1'b1;
            end
            PH_WALK: begin
                o_lamps.car_red    = 1'b1;
                o_lamps.walk_green = 1'b1;
            end
            default: begin
                o_lamps.car_yellow  = on_part;
                o_lamps.walk_yellow = on_part;
            end
        endcase
    end

    // Next state.
    always_comb begin
        o_next = s_eff;
        if (i_press && (s_eff.phase <= PH_RED)) begin
            o_next.request_pending = 1'b1;
        end

        unique case (s_eff.phase)
            PH_GREEN, PH_RED: begin
                o_next.tick_count = tc_inc;
                if (tc_inc >= {4'd0, i_cfg.slice_ticks}) begin
                    o_next.tick_count = '0;
                    if (o_next.request_pending) begin
                        o_next.came_from_red = 1'b0;
                        o_next = enter_phase(o_next,
                            (s_eff.phase == PH_GREEN) ? PH_BLINK_IN : PH_WALK);
                    end else begin
                        o_next.round_count = rc_inc;
                        if (slices_hit) begin
                            o_next.came_from_red = (s_eff.phase == PH_RED);
                            o_next = enter_phase(o_next, PH_CAR_BLINK);
                        end
                    end
                end
            end
            PH_WALK: begin
                o_next.tick_count = tc_inc;
                if (tc_inc >= i_cfg.walk_ticks) begin
                    o_next = enter_phase(o_next, PH_BLINK_OUT);
                end
            end
            default: begin
                // All three blink phases share the on-off-on sequencing.
                o_next.tick_count = tc_inc;
                if (!tick_lt_dur) begin
                    o_next.tick_count = '0;
                    if (s_eff.blink_part < BP_ON_LAST) begin
                        o_next.blink_part = s_eff.blink_part + 2'd1;
                    end else begin
                        o_next.blink_part = BP_ON_FIRST;
                    end
                end
                if (blink_end) begin
                    if ((s_eff.phase == PH_CAR_BLINK) && o_next.request_pending) begin
                        o_next.came_from_red = 1'b0;
                        o_next = enter_phase(o_next, PH_BLINK_IN);
                    end else begin
                        o_next.round_count = rc_inc;
                        if (rounds_hit) begin
                            if (s_eff.phase == PH_CAR_BLINK) begin
                                o_next = enter_phase(o_next,
                                    s_eff.came_from_red ? PH_GREEN : PH_RED);
                                o_next.came_from_red = 1'b0;
                            end else if (s_eff.phase == PH_BLINK_IN) begin
                                o_next = enter_phase(o_next, PH_WALK);
                            end else begin
                                o_next.request_pending = 1'b0;
                                o_next.came_from_red   = 1'b0;
                                o_next = enter_phase(o_next, PH_GREEN);
                            end
                        end
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> tb/lamp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lamp sequence checker
// Watches the tick, lamp and configuration channels of the pedestrian traffic
// light controller, predicts the lamp word of every accepted tick and compares
// the returned lamp words with those predictions in order.
// ----------------------------------------------------------------------------
module lamp_checker
    import ptl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick_valid,
    input  logic        i_tick_ready,
    input  logic [7:0]  i_tick_data,
    input  logic        i_lamp_valid,
    input  logic        i_lamp_ready,
    input  logic [15:0] i_lamp_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    t_cfg        timing;
    logic [2:0]  phase;
    logic        from_red;
    logic        walk_request;
    logic [15:0] tick_cnt;
    logic [7:0]  round_cnt;
    logic [1:0]  part;
    t_lamps      lamp_q[$];
    int          fail_cnt = 0;
    int          result_cnt = 0;

    task automatic start_phase(input logic [2:0] next);
        phase     = next;
        tick_cnt  = '0;
        round_cnt = '0;
        part      = BP_ON_FIRST;
    endtask

    // One tick of an on-off-on blink; returns 1 when a whole round has ended.
    function automatic logic blink_round_over(input logic [11:0] on_t,
                                              input logic [11:0] off_t);
        logic [11:0] span;
        span     = (part == BP_OFF) ? off_t : on_t;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt < {4'd0, span})
            return 1'b0;
        tick_cnt = '0;
        if (part < BP_ON_LAST) begin
            part = part + 2'd1;
            return 1'b0;
        end
        part = BP_ON_FIRST;
        return 1'b1;
    endfunction

    // A zero round count ends the phase after one round, since any count
    // compares greater or equal.
    function automatic logic all_rounds_done();
        round_cnt = round_cnt + 8'd1;
        return round_cnt >= timing.blink_rounds;
    endfunction

    task automatic predict_tick(input logic press, output t_lamps lamps);
        logic on_part;
        on_part = (part != BP_OFF);
        if (phase > PH_BLINK_OUT)
            start_phase(PH_GREEN);
        if (press && phase <= PH_RED)
            walk_request = 1'b1;

        lamps = '0;
        case (phase)
            PH_GREEN: begin
                lamps.car_green = 1'b1;
                lamps.walk_red  = 1'b1;
            end
            PH_CAR_BLINK: begin
                lamps.car_yellow = on_part;
                lamps.walk_red   = 1'b1;
            end
            PH_RED: begin
                lamps.car_red  = 1'b1;
                lamps.walk_red = 1'b1;
            end
            PH_WALK: begin
                lamps.car_red    = 1'b1;
                lamps.walk_green = 1'b1;
            end
            default: begin
                lamps.car_yellow  = on_part;
                lamps.walk_yellow = on_part;
            end
        endcase
        lamps.phase_now = phase;

        case (phase)
            PH_GREEN, PH_RED: begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= {4'd0, timing.slice_ticks}) begin
                    tick_cnt = '0;
                    if (walk_request) begin
                        from_red = 1'b0;
                        start_phase((phase == PH_GREEN) ? PH_BLINK_IN : PH_WALK);
                    end else begin
                        round_cnt = round_cnt + 8'd1;
                        if (round_cnt >= timing.slices_per_phase) begin
                            from_red = (phase == PH_RED);
                            start_phase(PH_CAR_BLINK);
                        end
                    end
                end
            end
            PH_CAR_BLINK: begin
                if (blink_round_over(timing.car_on_ticks, timing.car_off_ticks)) begin
                    if (walk_request) begin
                        from_red = 1'b0;
                        start_phase(PH_BLINK_IN);
                    end else if (all_rounds_done()) begin
                        start_phase(from_red ? PH_GREEN : PH_RED);
                        from_red = 1'b0;
                    end
                end
            end
            PH_BLINK_IN: begin
                if (blink_round_over(timing.both_on_ticks, timing.both_off_ticks)) begin
                    if (all_rounds_done())
                        start_phase(PH_WALK);
                end
            end
            PH_WALK: begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= timing.walk_ticks)
                    start_phase(PH_BLINK_OUT);
            end
            default: begin
                if (blink_round_over(timing.both_on_ticks, timing.both_off_ticks)) begin
                    if (all_rounds_done()) begin
                        walk_request = 1'b0;
                        from_red     = 1'b0;
                        start_phase(PH_GREEN);
                    end
                end
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [6:0] want,
                                 input logic [6:0] got);
        if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("lamp word %0d: %s expected %0d, got %0d",
                         result_cnt, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_lamps want;
        t_lamps got;
        if (!i_rst_n) begin
            timing = {RST_SLICE_TICKS, RST_SLICES_PER_PHASE, RST_CAR_ON_TICKS,
                      RST_CAR_OFF_TICKS, RST_BOTH_ON_TICKS, RST_BOTH_OFF_TICKS,
                      RST_WALK_TICKS, RST_BLINK_ROUNDS};
            from_red     = 1'b0;
            walk_request = 1'b0;
            start_phase(PH_GREEN);
            lamp_q.delete();
        end else begin
            // A lamp word always belongs to a tick taken at an earlier edge,
            // so it is matched before this edge's tick is predicted.
            if (i_lamp_valid && i_lamp_ready) begin
                result_cnt++;
                got = t_lamps'(i_lamp_data[8:0]);
                if (lamp_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("lamp word %0d: none expected, got %h",
                                 result_cnt, i_lamp_data);
                end else begin
                    want = lamp_q.pop_front();
                    compare_field("car_green", 7'(want.car_green), 7'(got.car_green));
                    compare_field("car_yellow", 7'(want.car_yellow), 7'(got.car_yellow));
                    compare_field("car_red", 7'(want.car_red), 7'(got.car_red));
                    compare_field("walk_green", 7'(want.walk_green), 7'(got.walk_green));
                    compare_field("walk_yellow", 7'(want.walk_yellow),
                                  7'(got.walk_yellow));
                    compare_field("walk_red", 7'(want.walk_red), 7'(got.walk_red));
                    compare_field("phase_now", 7'(want.phase_now), 7'(got.phase_now));
                    compare_field("padding", 7'd0, i_lamp_data[15:9]);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SLICE_TICKS:      timing.slice_ticks      = i_cfg_data[11:0];
                    REG_SLICES_PER_PHASE: timing.slices_per_phase = i_cfg_data[7:0];
                    REG_CAR_ON_TICKS:     timing.car_on_ticks     = i_cfg_data[11:0];
                    REG_CAR_OFF_TICKS:    timing.car_off_ticks    = i_cfg_data[11:0];
                    REG_BOTH_ON_TICKS:    timing.both_on_ticks    = i_cfg_data[11:0];
                    REG_BOTH_OFF_TICKS:   timing.both_off_ticks   = i_cfg_data[11:0];
                    REG_WALK_TICKS:       timing.walk_ticks       = i_cfg_data;
                    REG_BLINK_ROUNDS:     timing.blink_rounds     = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_tick_valid && i_tick_ready) begin
                predict_tick(i_tick_data[0], want);
                lamp_q.push_back(want);
            end
        end
        o_pending    <= lamp_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pedestrian traffic light testbench
// Sends button ticks to the controller under a series of timing settings,
// stalls both streams at random and lets the lamp checker compare every lamp
// word against its own prediction of the lamp sequence.
// ----------------------------------------------------------------------------
module testbench;
    import ptl_pkg::*;

    // Timing settings that the random part walks through.
    typedef enum int {
        SET_UNIT,       // every timer and count at 1, a two tick walk
        SET_TINY,       // short random timers, zeros and junk upper bits mixed in
        SET_MEDIUM,     // somewhat longer random timers
        SET_MAX,        // all data bits set: every register at its largest value
        SET_ZERO,       // every register zero, which must behave like one
        SET_LONG_WALK,  // quick path into the walk phase, then the longest walk
        SET_DEFAULTS    // the reset values written back explicitly
    } setting_kind_e;

    localparam int RANDOM_TICKS = 1100;
    localparam int IDLE_PCT     = 17;
    localparam int STEADY_CHUNK = 8;
    localparam int SCHEDULE_LEN = 7;
    localparam setting_kind_e SCHEDULE [SCHEDULE_LEN] = '{
        SET_MAX, SET_TINY, SET_ZERO, SET_MEDIUM, SET_LONG_WALK, SET_TINY, SET_DEFAULTS
    };

    // Directed press pattern under SET_UNIT, first tick leftmost. Tracing it:
    // a green phase and a car blink with no press; a press on the red check
    // tick, which must go straight to the walk without a joint blink in;
    // presses during the walk and the joint blink out, which must be ignored;
    // a press on a green check tick, which counts at that very check; and a
    // press in a car blink, which leaves the blink at the end of its round
    // into the joint blink in.
    localparam logic [0:23] DIRECTED_PRESSES = 24'b0000_1101_0011_0011_1000_1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int          lamps_pending;
    int          lamp_failures;
    logic        steady = 1'b0;     // no idling on either side while set
    logic [15:0] reg_image [0:7];   // register values for the next setting

    pedestrian_traffic_light_fsm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lamp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (s_axis_tvalid),
        .i_tick_ready (s_axis_tready),
        .i_tick_data  (s_axis_tdata),
        .i_lamp_valid (m_axis_tvalid),
        .i_lamp_ready (m_axis_tready),
        .i_lamp_data  (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (lamps_pending),
        .o_fail_count (lamp_failures)
    );

    // 8 ns clock period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The lamp receiver stalls in about one cycle of six, except during the
    // steady stretch. The handshake is sampled by the checker at the edge, and
    // ready only changes through nonblocking updates right after an edge.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one tick request, with random idle cycles in front of it, and
    // return at the edge that accepts it. Valid stays high into the next tick
    // when no idle cycle follows, so it is never dropped and raised in one step.
    task automatic send_tick(input logic press);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, press};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every predicted lamp word has come back.
    // The checker updates its count with nonblocking assignments, so the value
    // read after an edge covers everything up to the edge before it.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (lamps_pending != 0);
    endtask

    // Write all eight registers from reg_image, one request per register.
    task automatic write_regs();
        for (int r = 0; r < 8; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data  <= reg_image[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // A random register value from 1 to hi; now and then zero, and now and
    // then with junk above the register width, which the block must drop.
    function automatic logic [15:0] pick(input int hi, input int width);
        logic [15:0] v;
        v = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(hi, 1));
        if ($urandom_range(3) == 0)
            v = v | (16'($urandom) << width);
        return v;
    endfunction

    task automatic program_setting(input setting_kind_e kind);
        case (kind)
            SET_TINY: begin
                reg_image[REG_SLICE_TICKS]      = pick(4, 12);
                reg_image[REG_SLICES_PER_PHASE] = pick(3, 8);
                reg_image[REG_CAR_ON_TICKS]     = pick(4, 12);
                reg_image[REG_CAR_OFF_TICKS]    = pick(4, 12);
                reg_image[REG_BOTH_ON_TICKS]    = pick(4, 12);
                reg_image[REG_BOTH_OFF_TICKS]   = pick(4, 12);
                reg_image[REG_WALK_TICKS]       = pick(8, 16);
                reg_image[REG_BLINK_ROUNDS]     = pick(3, 8);
            end
            SET_MEDIUM: begin
                reg_image[REG_SLICE_TICKS]      = pick(20, 12);
                reg_image[REG_SLICES_PER_PHASE] = pick(8, 8);
                reg_image[REG_CAR_ON_TICKS]     = pick(25, 12);
                reg_image[REG_CAR_OFF_TICKS]    = pick(25, 12);
                reg_image[REG_BOTH_ON_TICKS]    = pick(25, 12);
                reg_image[REG_BOTH_OFF_TICKS]   = pick(25, 12);
                reg_image[REG_WALK_TICKS]       = pick(150, 16);
                reg_image[REG_BLINK_ROUNDS]     = pick(4, 8);
            end
            SET_MAX: begin
                foreach (reg_image[r])
                    reg_image[r] = 16'hFFFF;
            end
            SET_ZERO: begin
                foreach (reg_image[r])
                    reg_image[r] = 16'h0000;
            end
            SET_DEFAULTS: begin
                reg_image[REG_SLICE_TICKS]      = 16'(RST_SLICE_TICKS);
                reg_image[REG_SLICES_PER_PHASE] = 16'(RST_SLICES_PER_PHASE);
                reg_image[REG_CAR_ON_TICKS]     = 16'(RST_CAR_ON_TICKS);
                reg_image[REG_CAR_OFF_TICKS]    = 16'(RST_CAR_OFF_TICKS);
                reg_image[REG_BOTH_ON_TICKS]    = 16'(RST_BOTH_ON_TICKS);
                reg_image[REG_BOTH_OFF_TICKS]   = 16'(RST_BOTH_OFF_TICKS);
                reg_image[REG_WALK_TICKS]       = 16'(RST_WALK_TICKS);
                reg_image[REG_BLINK_ROUNDS]     = 16'(RST_BLINK_ROUNDS);
            end
            default: begin
                // SET_UNIT, and SET_LONG_WALK on top of it.
                foreach (reg_image[r])
                    reg_image[r] = 16'd1;
                reg_image[REG_WALK_TICKS] = (kind == SET_LONG_WALK) ? 16'hFFFF : 16'd2;
            end
        endcase
        write_regs();
    endtask

    // Main stimulus. Settings are only changed once every lamp word is back,
    // so a register write never lands between a tick and its lamp word. Each
    // new setting is written in the middle of whatever phase the last one left
    // the block in, which also lowers registers below running counts.
    initial begin
        int            sent;
        int            len;
        int            press_pct;
        setting_kind_e kind;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_SLICE_TICKS;
        i_cfg_data    <= 16'd0;
        i_rst_n       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with unit timing, so each phase lasts a tick or three.
        program_setting(SET_UNIT);
        for (int n = 0; n < 24; n++)
            send_tick(DIRECTED_PRESSES[n]);
        wait_drained();

        // Random part: runs of ticks under changing settings. Presses are
        // mostly rare, so that undisturbed normal cycles and the return from
        // red to green through the car blink occur as well as walk requests.
        sent = 0;
        for (int chunk = 0; sent < RANDOM_TICKS; chunk++) begin
            if (chunk < SCHEDULE_LEN)
                kind = SCHEDULE[chunk];
            else
                kind = $urandom_range(1) ? SET_TINY : SET_MEDIUM;
            program_setting(kind);

            press_pct = (1 << $urandom_range(5)) - 1;
            len = 60;
            case (kind)
                SET_MAX:       len = 50;
                SET_LONG_WALK: press_pct = 50;
                SET_DEFAULTS: begin
                    len       = 120;
                    press_pct = 3;
                end
                default: ;
            endcase
            if (chunk == STEADY_CHUNK)
                len = 150;
            steady <= (chunk == STEADY_CHUNK);

            for (int n = 0; n < len; n++)
                send_tick($urandom_range(99) < press_pct);
            sent += len;

            // Hold the sender off until the block has returned every word.
            wait_drained();
        end

        // Run on past the drain to catch any stray lamp word.
        repeat (4) @(posedge i_clk);
        if (lamp_failures == 0 && lamps_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
